// ===== src/e2utc_pkg.sv =====
// ----------------------------------------------------------------------------
// e2utc_pkg
// Constants and helpers for the epoch seconds to UTC calendar converter.
// ----------------------------------------------------------------------------
package e2utc_pkg;

    localparam int IN_W  = 32;
    localparam int OUT_W = 48;

    // Epoch day count offsets into the March-based year starting in 1 BC
    localparam logic [19:0] EPOCH_MDAYS  = 20'd719468;
    localparam logic [8:0]  YDAY_JAN     = 9'd306;

    // Ceiling reciprocals, exact over the operand ranges used here
    localparam logic [25:0] DAY_RECIP    = 26'(((64'd1 << 35) + 64'd674) / 64'd675);
    localparam logic [17:0] WEEK_RECIP   = 18'(((64'd1 << 20) + 64'd6) / 64'd7);
    localparam logic [29:0] YEAR_RECIP   = 30'(((64'd1 << 47) + 64'd146096) / 64'd146097);
    localparam logic [10:0] CENT_RECIP   = 11'(((64'd1 << 15) + 64'd24) / 64'd25);
    localparam logic [17:0] MIN_RECIP    = 18'(((64'd1 << 23) + 64'd59) / 64'd60);
    localparam logic [11:0] HOUR_RECIP   = 12'(((64'd1 << 17) + 64'd59) / 64'd60);
    localparam logic [16:0] MON_RECIP10  = 17'((((64'd1 << 21) + 64'd305) / 64'd306) * 64'd10);

    // Days before month m of the March-based year, offset by one (367*m/12 - 30)
    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] d;
        case (m)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd61;
            4'd4:    d = 9'd92;
            4'd5:    d = 9'd122;
            4'd6:    d = 9'd153;
            4'd7:    d = 9'd184;
            4'd8:    d = 9'd214;
            4'd9:    d = 9'd245;
            4'd10:   d = 9'd275;
            4'd11:   d = 9'd306;
            4'd12:   d = 9'd337;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// ===== src/epoch_seconds_to_utc_calendar.sv =====
// ----------------------------------------------------------------------------
// epoch_seconds_to_utc_calendar
// Converts 32-bit unsigned seconds since 1970-01-01 00:00 UTC into
// second, minute, hour, day of month, month, year and weekday.
// ----------------------------------------------------------------------------
// Eight-stage pipeline, one request per cycle while the output is not stalled.
// A request is registered in stage 1 on acceptance and moves through stages 2
// to 8, whose output register drives the master side. All divisions are by
// constants, done as reciprocal multiplies, one multiplier deep per stage.
// Each stage holds its request until the next stage frees, so bubbles close
// up and input is still taken while a finished result waits on the output,
// until all eight stages are full.
// No state is kept between requests.
module epoch_seconds_to_utc_calendar
    import e2utc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // [31:0] epoch_seconds
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata    // [5:0] second, [11:6] minute,
                                             // [16:12] hour, [21:17] day_of_month,
                                             // [25:22] month, [37:26] year,
                                             // [40:38] weekday, [47:41] zero
);

    localparam int NSTG = 8;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_rdy;

    always_comb begin
        w_rdy[NSTG-1] = !r_vld[NSTG-1] || m_axis_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    assign s_axis_tready = w_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage 1: whole days
    logic [50:0] n1_prod;
    logic [15:0] r1_days;
    logic [31:0] r1_secs;

    assign n1_prod = 51'(s_axis_tdata[31:7]) * 51'(DAY_RECIP);

    // Stage 2: second of day, weekday quotient, year estimate numerator
    logic [25:0] n2_dm;
    logic [25:0] n2_r;
    logic [16:0] n2_wk;
    logic [37:0] n2_wprod;
    logic [19:0] n2_md2;
    logic [16:0] r2_rem;
    logic [16:0] r2_wk;
    logic [12:0] r2_q7;
    logic [28:0] r2_x;
    logic [19:0] r2_mdays;

    assign n2_dm    = 26'(26'(r1_days) * 26'd675);
    assign n2_r     = 26'(r1_secs[31:7]) - n2_dm;
    assign n2_wk    = 17'(r1_days) + 17'd4;
    assign n2_wprod = 38'(n2_wk) * 38'(WEEK_RECIP);
    assign n2_md2   = 20'(r1_days) + EPOCH_MDAYS + 20'd2;

    // Stage 3: year estimate, minute of day, weekday
    logic [58:0] n3_yprod;
    logic [40:0] n3_mprod;
    logic [11:0] r3_year;
    logic [10:0] r3_minday;
    logic [16:0] r3_rem;
    logic [2:0]  r3_wday;
    logic [19:0] r3_mdays;

    assign n3_yprod = 59'(r2_x) * 59'(YEAR_RECIP);
    assign n3_mprod = 41'(r2_rem) * 41'(MIN_RECIP);

    // Stage 4: leap-day terms, second, hour
    logic [20:0] n4_cprod;
    logic [18:0] n4_qprod;
    logic [22:0] n4_hprod;
    logic [19:0] r4_y365;
    logic [9:0]  r4_c4;
    logic [4:0]  r4_c100;
    logic [2:0]  r4_c400;
    logic [11:0] r4_year;
    logic [19:0] r4_mdays;
    logic [10:0] r4_minday;
    logic [5:0]  r4_sec;
    logic [4:0]  r4_hour;
    logic [2:0]  r4_wday;

    assign n4_cprod = 21'(r3_year[11:2]) * 21'(CENT_RECIP);
    assign n4_qprod = 19'(r3_year[11:4]) * 19'(CENT_RECIP);
    assign n4_hprod = 23'(r3_minday) * 23'(HOUR_RECIP);

    // Stage 5: raw day of year, leap flag, minute
    logic [20:0] n5_sum;
    logic [20:0] n5_diff;
    logic        n5_leap;
    logic [10:0] r5_yday0;
    logic        r5_leap;
    logic [11:0] r5_year;
    logic [5:0]  r5_sec;
    logic [5:0]  r5_min;
    logic [4:0]  r5_hour;
    logic [2:0]  r5_wday;

    assign n5_sum  = 21'(r4_y365) + 21'(r4_c4) - 21'(r4_c100) + 21'(r4_c400);
    assign n5_diff = 21'(r4_mdays) - n5_sum;
    assign n5_leap = (r4_year[1:0] == 2'd0) &&
                     ((12'(12'(r4_c100) * 12'd100) != r4_year) ||
                      (12'(12'(r4_c400) * 12'd400) == r4_year));

    // Stage 6: correct year when the day of year came out negative
    logic [10:0] n6_fix;
    logic [8:0]  r6_yday;
    logic [11:0] r6_year;
    logic [5:0]  r6_sec;
    logic [5:0]  r6_min;
    logic [4:0]  r6_hour;
    logic [2:0]  r6_wday;

    assign n6_fix = r5_yday0 + 11'd365 + 11'(r5_leap);

    // Stage 7: March-based month
    logic [26:0] n7_mprod;
    logic [3:0]  r7_mon;
    logic [8:0]  r7_yday;
    logic [11:0] r7_year;
    logic [5:0]  r7_sec;
    logic [5:0]  r7_min;
    logic [4:0]  r7_hour;
    logic [2:0]  r7_wday;

    assign n7_mprod = 27'(10'(r6_yday) + 10'd31) * 27'(MON_RECIP10);

    // Stage 8: day of month, calendar month and year fix-up, output register
    logic [8:0]  n8_dom;
    logic        n8_jan;
    logic [5:0]  r8_sec;
    logic [5:0]  r8_min;
    logic [4:0]  r8_hour;
    logic [4:0]  r8_dom;
    logic [3:0]  r8_mon;
    logic [11:0] r8_year;
    logic [2:0]  r8_wday;

    assign n8_dom = r7_yday - days_before(r7_mon) + 9'd1;
    assign n8_jan = (r7_yday >= YDAY_JAN);

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r1_days <= n1_prod[50:35];
            r1_secs <= s_axis_tdata;
        end
        if (w_rdy[1]) begin
            r2_rem   <= {n2_r[9:0], r1_secs[6:0]};
            r2_wk    <= n2_wk;
            r2_q7    <= 13'(n2_wprod >> 20);
            r2_x     <= 29'(29'(n2_md2) * 29'd400);
            r2_mdays <= n2_md2 - 20'd2;
        end
        if (w_rdy[2]) begin
            r3_year   <= n3_yprod[58:47];
            r3_minday <= 11'(n3_mprod >> 23);
            r3_rem    <= r2_rem;
            r3_wday   <= 3'(r2_wk - 17'(17'(r2_q7) * 17'd7));
            r3_mdays  <= r2_mdays;
        end
        if (w_rdy[3]) begin
            r4_y365   <= 20'(20'(r3_year) * 20'd365);
            r4_c4     <= r3_year[11:2];
            r4_c100   <= 5'(n4_cprod >> 15);
            r4_c400   <= 3'(n4_qprod >> 15);
            r4_year   <= r3_year;
            r4_mdays  <= r3_mdays;
            r4_minday <= r3_minday;
            r4_sec    <= 6'(r3_rem - 17'(17'(r3_minday) * 17'd60));
            r4_hour   <= 5'(n4_hprod >> 17);
            r4_wday   <= r3_wday;
        end
        if (w_rdy[4]) begin
            r5_yday0 <= n5_diff[10:0];
            r5_leap  <= n5_leap;
            r5_year  <= r4_year;
            r5_sec   <= r4_sec;
            r5_min   <= 6'(r4_minday - 11'(11'(r4_hour) * 11'd60));
            r5_hour  <= r4_hour;
            r5_wday  <= r4_wday;
        end
        if (w_rdy[5]) begin
            if (r5_yday0[10]) begin
                r6_yday <= n6_fix[8:0];
                r6_year <= r5_year - 12'd1;
            end else begin
                r6_yday <= r5_yday0[8:0];
                r6_year <= r5_year;
            end
            r6_sec  <= r5_sec;
            r6_min  <= r5_min;
            r6_hour <= r5_hour;
            r6_wday <= r5_wday;
        end
        if (w_rdy[6]) begin
            r7_mon  <= 4'(n7_mprod >> 21);
            r7_yday <= r6_yday;
            r7_year <= r6_year;
            r7_sec  <= r6_sec;
            r7_min  <= r6_min;
            r7_hour <= r6_hour;
            r7_wday <= r6_wday;
        end
        if (w_rdy[7]) begin
            r8_dom  <= n8_dom[4:0];
            if (n8_jan) begin
                r8_mon  <= r7_mon - 4'd10;
                r8_year <= r7_year + 12'd1;
            end else begin
                r8_mon  <= r7_mon + 4'd2;
                r8_year <= r7_year;
            end
            r8_sec  <= r7_sec;
            r8_min  <= r7_min;
            r8_hour <= r7_hour;
            r8_wday <= r7_wday;
        end
    end

    assign m_axis_tvalid = r_vld[NSTG-1];
    assign m_axis_tdata  = {7'd0, r8_wday, r8_year, r8_mon, r8_dom,
                            r8_hour, r8_min, r8_sec};

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for epoch_seconds_to_utc_calendar. Every accepted
// timestamp is converted by an in-bench calendar predictor, and each output
// request is compared field by field against the oldest pending date.
// Directed corners (range ends, day, month, year and leap-day edges) are
// followed by a full-rate burst, a long output hold-off and random timestamps
// with random idle on both streams.
// ----------------------------------------------------------------------------
module tb_top
    import e2utc_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int HOLD_OFF_LEN   = 64;
    localparam int LAST_DAY       = 49709;

    typedef struct packed {
        logic [2:0]  weekday;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } utc_time_t;

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata  = '0;   // [31:0] epoch_seconds
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;         // [5:0] second, [11:6] minute, [16:12] hour,
                                            // [21:17] day_of_month, [25:22] month,
                                            // [37:26] year, [40:38] weekday, [47:41] zero

    utc_time_t pending_dates[$];
    int        n_requests   = 0;
    int        n_results    = 0;
    int        n_fail       = 0;
    int        idle_cycles  = 0;
    int        hold_off_len = 0;
    bit        no_idle      = 1'b0;

    epoch_seconds_to_utc_calendar dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Gregorian calendar breakdown via a March-based year starting in 1 BC
    function automatic utc_time_t utc_from_epoch(input logic [31:0] secs);
        utc_time_t t;
        longint    days;
        longint    sod;
        longint    march_days;
        longint    yr;
        longint    doy;
        longint    mon;
        longint    mday;
        days       = longint'(secs) / 86400;
        sod        = longint'(secs) % 86400;
        march_days = days + 719468;
        yr         = (march_days + 2) * 400 / 146097;
        doy        = march_days - (365 * yr + yr / 4 - yr / 100 + yr / 400);
        if (doy < 0) begin
            doy += ((yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0))) ? 366 : 365;
            yr--;
        end
        mon  = (doy + 31) * 10 / 306;
        mday = doy - (367 * mon / 12 - 30) + 1;
        if (doy >= 306) begin
            yr++;
            mon -= 10;
        end else begin
            mon += 2;
        end
        t.second       = 6'(sod % 60);
        t.minute       = 6'((sod % 3600) / 60);
        t.hour         = 5'(sod / 3600);
        t.day_of_month = 5'(mday);
        t.month        = 4'(mon);
        t.year         = 12'(yr);
        t.weekday      = 3'((days + 4) % 7);
        return t;
    endfunction

    function automatic void compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            n_fail++;
        end
    endfunction

    always @(posedge i_clk) begin : scoreboard
        utc_time_t want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                pending_dates.push_back(utc_from_epoch(s_axis_tdata));
                n_requests++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                n_results++;
                if (pending_dates.size() == 0) begin
                    $error("result with no pending request: tdata=%h", m_axis_tdata);
                    n_fail++;
                end else begin
                    want = pending_dates.pop_front();
                    compare_field("second", int'(want.second), int'(m_axis_tdata[5:0]));
                    compare_field("minute", int'(want.minute), int'(m_axis_tdata[11:6]));
                    compare_field("hour", int'(want.hour), int'(m_axis_tdata[16:12]));
                    compare_field("day_of_month", int'(want.day_of_month),
                                  int'(m_axis_tdata[21:17]));
                    compare_field("month", int'(want.month), int'(m_axis_tdata[25:22]));
                    compare_field("year", int'(want.year), int'(m_axis_tdata[37:26]));
                    compare_field("weekday", int'(want.weekday),
                                  int'(m_axis_tdata[40:38]));
                    compare_field("pad", 0, int'(m_axis_tdata[47:41]));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result sink: random wait per request, plus an occasional long hold-off
    initial begin : result_sink
        int gap;
        int held;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_len > 0) begin
                held         = hold_off_len;
                hold_off_len = 0;
                m_axis_tready <= 1'b0;
                repeat (held) @(posedge i_clk);
            end
            gap = no_idle ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    task automatic send_request(input logic [31:0] secs);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= secs;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    function automatic logic [31:0] random_epoch();
        longint day;
        longint sod;
        if ($urandom_range(0, 9) < 6)
            return $urandom();
        day = $urandom_range(0, LAST_DAY);
        case ($urandom_range(0, 2))
            0:       sod = 0;
            1:       sod = 86399;
            default: sod = $urandom_range(0, 86399);
        endcase
        return 32'(day * 86400 + sod);
    endfunction

    task automatic test_directed_corners();
        logic [31:0] corners[$];
        corners = '{32'd0, 32'hFFFF_FFFF, 32'd59, 32'd60, 32'd3599, 32'd3600,
                    32'd86399, 32'd86400, 32'd5097600, 32'd31535999, 32'd31536000,
                    32'd68169600, 32'd946684799, 32'd946684800, 32'd951782400,
                    32'd951868800, 32'h7FFF_FFFF, 32'h8000_0000, 32'd4102444800,
                    32'd4107456000, 32'd4107542400, 32'hAAAA_AAAA, 32'h5555_5555};
        foreach (corners[i]) send_request(corners[i]);
    endtask

    task automatic test_full_rate(input int count);
        no_idle = 1'b1;
        repeat (count) send_request(random_epoch());
        no_idle = 1'b0;
    endtask

    task automatic test_output_hold_off(input int count);
        hold_off_len = HOLD_OFF_LEN;
        no_idle      = 1'b1;
        repeat (count) send_request(random_epoch());
        no_idle      = 1'b0;
    endtask

    task automatic test_random_epochs(input int count);
        repeat (count) send_request(random_epoch());
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_corners();
        test_full_rate(200);
        test_output_hold_off(100);
        test_random_epochs(1230);

        s_axis_tvalid <= 1'b0;
        while (pending_dates.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Converted %0d timestamps, checked %0d calendar results,", n_requests,
                 n_results);
        $display("covering range ends, leap days, year edges and a stalled output.");
        if (n_fail == 0 && pending_dates.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
